// ===== sv/bfnf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfnf_pkg
// Shared types and constants for the four-neighbor binary fill block.
// ---------------------------------------------------------------------------
package bfnf_pkg;

   localparam int SIZE_W         = 8;    // image_size register width
   localparam int RESET_SIZE     = 128;  // image_size after reset
   localparam int FILL_THRESHOLD = 3;    // neighbors needed to fill a zero pixel
   localparam int CNT_W          = 3;    // neighbor count width, 0..4

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // one line-buffer cell: row r-1 bit and row r-2 bit
   typedef struct packed {
      logic middle;
      logic older;
   } cell_bits_type;

   // one result word
   typedef struct packed {
      logic pixel;
      logic row_end;
      logic frame_end;
   } rsp_word_type;

endpackage

// ===== sv/bfnf_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfnf_cell
// One column slot of the two line buffers. On every step it takes its
// right neighbor's bits, or the newly entering bits when it is the tail.
// ---------------------------------------------------------------------------
module bfnf_cell (
   input  logic                   clock,
   input  logic                   shift,
   input  logic                   tail,
   input  bfnf_pkg::cell_bits_type from_right,
   input  bfnf_pkg::cell_bits_type from_head,
   output bfnf_pkg::cell_bits_type bits
);
   import bfnf_pkg::*;

   cell_bits_type bits_ff;
   cell_bits_type bits_in;

   always_comb begin
      bits_in = bits_ff;
      if (shift) begin
         bits_in = tail ? from_head : from_right;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

   assign bits = bits_ff;

endmodule

// ===== sv/bfnf_out_buf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfnf_out_buf
// Output register with a skid stage; upstream ready is registered.
// ---------------------------------------------------------------------------
module bfnf_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bfnf_pkg::rsp_word_type in_word,
   output logic                  in_ready,
   output logic                  out_valid,
   output bfnf_pkg::rsp_word_type out_word,
   input  logic                  out_ready
);
   import bfnf_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_valid_ff && out_ready) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_word_in  = in_word;
         end
      end else if (out_valid_ff) begin
         if (in_valid) begin
            skid_valid_in = 1'b1;
            skid_word_in  = in_word;
         end
      end else begin
         out_valid_in = in_valid;
         out_word_in  = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

// ===== sv/binary_four_neighbor_fill.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_four_neighbor_fill
// Streaming four-neighbor hole fill of a square binary image.
// ---------------------------------------------------------------------------
// Usage:
//  req_*  : one word per pixel in raster order (tuser = cmd, tdata[0] = pixel).
//           After the last row send N drain words (cmd = 1) to flush it.
//  rsp_*  : one word per pixel of the previous row; tlast ends a row,
//           tuser[0] ends the frame. Row 0 produces no words.
//  csr_*  : writes image_size (N); any write restarts the frame at row 0.
//           Write only while the block is idle.
// Results are registered: a result reaches rsp_tvalid through the output
// register or its skid word. Throughput is one word per cycle while
// req_tready is high: the line buffers are a chain of cells that shift one
// column per pixel or flush word; there is no memory port to contend for.
// Stall: the output register plus a skid word let req_tready stay high for
// one more result word while rsp_tready is low; req_tready then drops until
// the skid word drains.
// Reset: counters clear, image_size returns to 128 (clamped to MAX_SIZE),
// buffer contents are left as they are and are rewritten by row 0.
// ---------------------------------------------------------------------------
module binary_four_neighbor_fill #(
   parameter int MAX_SIZE = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] pixel_in, [7:1] zero
   input  logic [0:0] req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] pixel_out, [7:1] zero
   output logic       rsp_tlast,   // row_end
   output logic [0:0] rsp_tuser,   // [0] frame_end
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data     // image_size
);
   import bfnf_pkg::*;

   localparam int CW      = $clog2(MAX_SIZE + 1);
   localparam int SW      = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int RESET_N = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;

   logic [CW-1:0] side_ff, side_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          left_ff, left_in;
   logic [SW-1:0] size_ext;

   logic          accept, step, draining, last_col, emit;
   logic          cmd, pix;
   logic [CNT_W-1:0] count;
   rsp_word_type  new_word;

   cell_bits_type chain [0:MAX_SIZE];
   cell_bits_type head_bits;

   // clamp the written size to 1..MAX_SIZE
   assign size_ext = SW'(csr_data);
   always_comb begin
      if (csr_data == '0) begin
         side_in = CW'(1);
      end else if (size_ext > SW'(MAX_SIZE)) begin
         side_in = CW'(MAX_SIZE);
      end else begin
         side_in = CW'(size_ext);
      end
   end

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign cmd       = req_tuser[0];
   assign pix       = req_tdata[0];
   assign draining  = (row_ff >= side_ff);
   // early drain words are dropped without touching state
   assign step      = accept && (draining || cmd == CMD_PIXEL);
   assign last_col  = ((col_ff + CW'(1)) == side_ff);
   assign emit      = step && (row_ff != '0);

   // chain[0] is column c, chain[1] column c+1 of row r-1 / r-2
   assign head_bits.middle = draining ? chain[0].middle : pix;
   assign head_bits.older  = chain[0].middle;
   assign chain[MAX_SIZE]  = head_bits;

   for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
      bfnf_cell u_cell (
         .clock      (clock),
         .shift      (step),
         .tail       (side_ff == CW'(i + 1)),
         .from_right (chain[i+1]),
         .from_head  (head_bits),
         .bits       (chain[i])
      );
   end

   always_comb begin
      count = '0;
      if (row_ff > CW'(1)) count = count + CNT_W'(chain[0].older);
      if (!draining)       count = count + CNT_W'(pix);
      if (col_ff != '0)    count = count + CNT_W'(left_ff);
      if (!last_col)       count = count + CNT_W'(chain[1].middle);
   end

   assign new_word.pixel     = chain[0].middle || (count >= CNT_W'(FILL_THRESHOLD));
   assign new_word.row_end   = last_col;
   assign new_word.frame_end = draining && last_col;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      left_in = left_ff;
      if (csr_valid) begin
         row_in = '0;
         col_in = '0;
      end else if (step) begin
         left_in = chain[0].middle;
         if (last_col) begin
            col_in = '0;
            row_in = draining ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= CW'(RESET_N);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         if (csr_valid) begin
            side_ff <= side_in;
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   rsp_word_type out_word;

   bfnf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit),
      .in_word   (new_word),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata    = {7'b0, out_word.pixel};
   assign rsp_tlast    = out_word.row_end;
   assign rsp_tuser[0] = out_word.frame_end;

`ifndef ASSERT_OFF
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < side_ff)
      else $error("column counter beyond image side");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= side_ff)
      else $error("row counter beyond drain row");

   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("frame end word does not end a row");
`endif

endmodule
